// ===== sv/bwlh_pkg.sv =====
// Shared types, microcode encoding and control program for the bounded-wait lock handoff core.
// It depends on nothing and is used by bwlh_seq and bounded_wait_lock_handoff_core.
`timescale 1ns / 1ps

package bwlh_pkg;

  // Default number of waiting bits that the core keeps.
  localparam int MAX_CLIENTS_DEF = 8;

  // Width of the step counter of the control program.
  localparam int PC_W = 3;

  // Register map of the configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_COUNT = 2'd0;
  localparam logic [3:0] ACTIVE_COUNT_RST = 4'd8;

  // Input action codes.
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // One input word.
  typedef struct packed {
    logic       action;
    logic [2:0] client_id;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic       granted;
    logic [2:0] grant_id;
    logic       lock_held;
  } out_word_t;

  // Datapath operations that one control word can order.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_REQ,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_FREE,
    OP_EMIT
  } op_t;

  // Jump conditions; a false condition falls through to the next step.
  typedef enum logic [2:0] {
    CC_NEVER,
    CC_ALWAYS,
    CC_NO_INPUT,
    CC_INACTIVE,
    CC_IS_RELEASE,
    CC_LOCK_FREE,
    CC_SCAN_MORE,
    CC_OUT_BUSY
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  // One control word of the program.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  // Status flags that the datapath returns to the sequencer.
  typedef struct packed {
    logic no_input;
    logic inactive;
    logic is_release;
    logic lock_free;
    logic scan_more;
    logic out_busy;
  } seq_flags_t;

  // Program steps, named for their jump targets.
  localparam pc_t PC_IDLE   = 3'd0;
  localparam pc_t PC_CHECK  = 3'd1;
  localparam pc_t PC_ROUTE  = 3'd2;
  localparam pc_t PC_REQ    = 3'd3;
  localparam pc_t PC_REL    = 3'd4;
  localparam pc_t PC_SCAN   = 3'd5;
  localparam pc_t PC_FREE   = 3'd6;
  localparam pc_t PC_EMIT   = 3'd7;

  // Control program. The last step falls through and wraps back to idle.
  function automatic ctrl_word_t ucode_rom(input pc_t pc);
    ctrl_word_t w;
    begin
      w = '{op: OP_NOP, cond: CC_NEVER, target: PC_IDLE};
      unique case (pc)
        PC_IDLE:  w = '{op: OP_LATCH,     cond: CC_NO_INPUT,   target: PC_IDLE};
        PC_CHECK: w = '{op: OP_NOP,       cond: CC_INACTIVE,   target: PC_EMIT};
        PC_ROUTE: w = '{op: OP_NOP,       cond: CC_IS_RELEASE, target: PC_REL};
        PC_REQ:   w = '{op: OP_REQ,       cond: CC_ALWAYS,     target: PC_EMIT};
        PC_REL:   w = '{op: OP_SCAN_INIT, cond: CC_LOCK_FREE,  target: PC_EMIT};
        PC_SCAN:  w = '{op: OP_SCAN,      cond: CC_SCAN_MORE,  target: PC_SCAN};
        PC_FREE:  w = '{op: OP_FREE,      cond: CC_NEVER,      target: PC_IDLE};
        PC_EMIT:  w = '{op: OP_EMIT,      cond: CC_OUT_BUSY,   target: PC_EMIT};
        default:  w = '{op: OP_NOP,       cond: CC_NEVER,      target: PC_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

// ===== sv/bwlh_seq.sv =====
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// It depends on bwlh_pkg for the control word, conditions and the program itself.
`timescale 1ns / 1ps

module bwlh_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  bwlh_pkg::seq_flags_t flags,
  output bwlh_pkg::op_t       op
);
  import bwlh_pkg::*;

  pc_t        pc_r;
  pc_t        pc_nxt;
  ctrl_word_t cw;
  logic       take;

  // Fetch the control word of the current step.
  assign cw = ucode_rom(pc_r);
  assign op = cw.op;

  // Evaluate the jump condition of this step.
  always_comb begin
    unique case (cw.cond)
      CC_NEVER:      take = 1'b0;
      CC_ALWAYS:     take = 1'b1;
      CC_NO_INPUT:   take = flags.no_input;
      CC_INACTIVE:   take = flags.inactive;
      CC_IS_RELEASE: take = flags.is_release;
      CC_LOCK_FREE:  take = flags.lock_free;
      CC_SCAN_MORE:  take = flags.scan_more;
      CC_OUT_BUSY:   take = flags.out_busy;
      default:       take = 1'b0;
    endcase
  end

  // Jump or fall through; the counter wraps from the last step to idle.
  assign pc_nxt = take ? cw.target : pc_r + pc_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== sv/bounded_wait_lock_handoff_core.sv =====
// Bounded-waiting mutex with round-robin handoff. One word is taken at a time: a request
// passes the check, route and request steps to the emit step, an id outside the active count
// goes from the check step straight to emit, and a release of a held lock runs the handoff
// scan, which examines one waiting bit per cycle around the ring before the free step. The next word
// is accepted as soon as the result sits in the output register, even while it still waits
// to be taken. A microcoded sequencer (bwlh_seq) drives this datapath; it depends on bwlh_pkg.
`timescale 1ns / 1ps

module bounded_wait_lock_handoff_core #(
  parameter int MAX_CLIENTS = bwlh_pkg::MAX_CLIENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input words
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bwlh_pkg::in_word_t                   in_data,
  // Result words
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bwlh_pkg::out_word_t                  out_data,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bwlh_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import bwlh_pkg::*;

  // Index width into the waiting bits and width of counts compared against the ring size.
  localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int NW = $clog2(MAX_CLIENTS + 1);
  localparam int AW = (NW > 4) ? NW : 4;

  logic [3:0]             active_r;
  logic                   lock_r;
  logic [MAX_CLIENTS-1:0] wait_r;
  logic                   action_r;
  logic [AW-1:0]          id_r;
  logic [AW-1:0]          n_r;
  logic [IW-1:0]          j_r;
  logic [AW-1:0]          k_r;
  logic                   granted_r;
  logic [2:0]             gid_r;
  logic                   out_valid_r;
  out_word_t              out_data_r;

  op_t           op;
  seq_flags_t    flags;
  logic          accept;
  logic          cfg_wr;
  logic [AW-1:0] act_ext;
  logic [AW-1:0] n_eff;
  logic [AW-1:0] id_ext;
  logic [AW-1:0] j_ext;
  logic [AW-1:0] j_step;
  logic [AW-1:0] id_step;
  logic          hit;
  logic          out_busy;

  // Configuration register write and read-back.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_ACTIVE_COUNT);
  assign prdata = (paddr == REG_ACTIVE_COUNT) ? {28'd0, active_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_COUNT_RST;
    end else if (cfg_wr) begin
      active_r <= pwdata[3:0];
    end
  end

  // Effective ring size: zero counts as one, and the count is capped at the bit count.
  assign act_ext = AW'(active_r);
  assign n_eff   = (act_ext == '0) ? AW'(1) :
                   (act_ext > AW'(MAX_CLIENTS)) ? AW'(MAX_CLIENTS) : act_ext;
  assign id_ext  = AW'(in_data.client_id);

  // Ring arithmetic for the scan pointer.
  assign j_ext   = AW'(j_r);
  assign j_step  = (j_ext + AW'(1) == n_r) ? '0 : j_ext + AW'(1);
  assign id_step = (id_r + AW'(1) == n_r) ? '0 : id_r + AW'(1);
  assign hit     = (k_r < n_r) && wait_r[j_r];

  // Handshakes.
  assign in_stall  = (op != OP_LATCH);
  assign accept    = in_valid && !in_stall;
  assign out_busy  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status flags for the sequencer.
  always_comb begin
    flags.no_input   = !in_valid;
    flags.inactive   = !(id_r < n_r);
    flags.is_release = (action_r == ACT_RELEASE);
    flags.lock_free  = !lock_r;
    flags.scan_more  = !hit && (k_r + AW'(1) < n_r);
    flags.out_busy   = out_busy;
  end

  bwlh_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  // Lock flag and waiting bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r <= 1'b0;
      wait_r <= '0;
    end else begin
      case (op)
        OP_REQ: begin
          if (!lock_r) begin
            lock_r <= 1'b1;
          end else begin
            wait_r[IW'(id_r)] <= 1'b1;
          end
        end
        OP_SCAN: begin
          if (hit) begin
            wait_r[j_r] <= 1'b0;
          end
        end
        OP_FREE: begin
          if (!granted_r) begin
            lock_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        if (accept) begin
          action_r  <= in_data.action;
          id_r      <= id_ext;
          n_r       <= n_eff;
          granted_r <= 1'b0;
          gid_r     <= 3'd0;
        end
      end
      OP_REQ: begin
        if (!lock_r) begin
          granted_r <= 1'b1;
          gid_r     <= 3'(id_r);
        end
      end
      OP_SCAN_INIT: begin
        j_r <= IW'(id_step);
        k_r <= AW'(1);
      end
      OP_SCAN: begin
        if (hit) begin
          granted_r <= 1'b1;
          gid_r     <= 3'(j_ext);
        end else begin
          j_r <= IW'(j_step);
          k_r <= k_r + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register; the result is loaded once the previous one has gone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_EMIT && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT && !out_busy) begin
      out_data_r.granted   <= granted_r;
      out_data_r.grant_id  <= gid_r;
      out_data_r.lock_held <= lock_r;
    end
  end

  // A new result only appears after an emit step.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(op == OP_EMIT))
    else $error("result appeared without an emit step");

  // A granted result always reports the lock as held.
  a_grant_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.granted) |-> out_data_r.lock_held)
    else $error("grant reported with the lock free");

  // Only one word is in work: after an accept the input stalls.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second word accepted while one is in work");

  // The scan never hands the lock over when the lock was free.
  a_scan_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_SCAN) |-> lock_r)
    else $error("handoff scan ran with the lock free");

endmodule
